// ===== rtl/core/sv32ptw_pkg.sv =====
// Package for the Sv32 page table walker: field widths, codes and the result record.
`timescale 1ns / 1ps
`default_nettype none

package sv32ptw_pkg;

    localparam int XLEN      = 32;
    localparam int PPN_W     = 22;
    localparam int VPN_W     = 10;
    localparam int OFFSET_W  = 12;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_AD     = 2'd2;

    // Input item function
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_PTE     = 1'b1;

    // Access types
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    // Privilege
    localparam logic PRIV_USER = 1'b1;

    // PTE bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;
    localparam int PTE_A = 6;
    localparam int PTE_D = 7;

    typedef struct packed {
        logic [1:0]      kind;
        logic [XLEN-1:0] address;
        logic [1:0]      read_kind;
        logic [1:0]      fault_cause;
        logic [XLEN-1:0] fault_vaddr;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sv32ptw_if.sv =====
// Channel interfaces of the Sv32 page table walker: request, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface sv32ptw_in_if;
    import sv32ptw_pkg::*;
    logic            valid;
    logic            ready;
    logic            func;
    logic [XLEN-1:0] vaddr;
    logic [1:0]      access_type;
    logic [XLEN-1:0] pte_word;

    modport source (output valid, output func, output vaddr, output access_type,
                    output pte_word, input ready);
    modport sink   (input valid, input func, input vaddr, input access_type,
                    input pte_word, output ready);
endinterface

interface sv32ptw_out_if;
    import sv32ptw_pkg::*;
    logic            valid;
    logic            ready;
    logic [1:0]      kind;
    logic [XLEN-1:0] address;
    logic [1:0]      read_kind;
    logic [1:0]      fault_cause;
    logic [XLEN-1:0] fault_vaddr;

    modport source (output valid, output kind, output address, output read_kind,
                    output fault_cause, output fault_vaddr, input ready);
    modport sink   (input valid, input kind, input address, input read_kind,
                    input fault_cause, input fault_vaddr, output ready);
endinterface

interface sv32ptw_cfg_if;
    import sv32ptw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [XLEN-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sv32_page_table_walker.sv =====
// Top level of the two-level Sv32 page table walker.
//
//   channel  direction  payload                                           role
//   req      in         func, vaddr, access_type, pte_word                request or PTE return
//   rsp      out        kind, address, read_kind, fault_cause, fault_vaddr read, done or fault
//   cfg      in         index, data                                       register write
//
// Each transaction on req is decoded combinationally and its result, if any, is held
// in the output register; a new transaction is taken every cycle the output
// register is empty or being drained, so one item per cycle is sustained.
// Reset clears the walk state, the configuration and the output valid flag.
// A stall on rsp holds req ready low until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sv32_page_table_walker
    import sv32ptw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    sv32ptw_in_if.sink     req,
    sv32ptw_out_if.source  rsp,
    sv32ptw_cfg_if.sink    cfg
);

    logic [PPN_W-1:0] root_ppn_reg;
    logic             priv_mode_reg;
    logic             check_ad_reg;

    logic             busy_reg,  busy_next;
    logic             level_reg, level_next;
    logic [XLEN-1:0]  saved_vaddr_reg, saved_vaddr_next;
    logic [1:0]       saved_type_reg,  saved_type_next;

    logic             out_valid_reg;
    result_t          out_reg;

    logic             accept;
    logic             res_valid;
    result_t          res;

    logic [1:0]       req_type;
    logic             pte_v, pte_r, pte_w, pte_x, pte_u, pte_a, pte_d;
    logic             perm, ad_fault;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign req_type = (req.access_type == 2'd3) ? ACC_STORE : req.access_type;

    assign pte_v = req.pte_word[PTE_V];
    assign pte_r = req.pte_word[PTE_R];
    assign pte_w = req.pte_word[PTE_W];
    assign pte_x = req.pte_word[PTE_X];
    assign pte_u = req.pte_word[PTE_U];
    assign pte_a = req.pte_word[PTE_A];
    assign pte_d = req.pte_word[PTE_D];

    always_comb
    begin
        case (saved_type_reg)
            ACC_FETCH:
            begin
                perm     = pte_x;
                ad_fault = !pte_a;
            end
            ACC_LOAD:
            begin
                perm     = pte_r;
                ad_fault = !pte_a;
            end
            default:
            begin
                perm     = pte_w;
                ad_fault = !pte_a || !pte_d;
            end
        endcase
    end

    always_comb
    begin
        busy_next        = busy_reg;
        level_next       = level_reg;
        saved_vaddr_next = saved_vaddr_reg;
        saved_type_next  = saved_type_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (req.func == FUNC_REQUEST)
        begin
            saved_vaddr_next = req.vaddr;
            saved_type_next  = req_type;
            busy_next        = 1'b1;
            level_next       = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_READ;
            // root base truncated to 32 bits; VPN[1]*4 fills the page offset
            res.address      = {root_ppn_reg[XLEN-OFFSET_W-1:0],
                                req.vaddr[XLEN-1:OFFSET_W+VPN_W], 2'b00};
            res.read_kind    = req_type;
        end
        else if (busy_reg)
        begin
            res_valid       = 1'b1;
            res.kind        = KIND_FAULT;
            res.fault_cause = saved_type_reg;
            res.fault_vaddr = saved_vaddr_reg;
            busy_next       = 1'b0;
            level_next      = 1'b1;

            if (!pte_v || (!pte_r && pte_w))
            begin
                // invalid or write-only entry: fault
            end
            else if (!pte_r && !pte_x)
            begin
                if (level_reg)
                begin
                    // pointer to the next level: issue the level-0 read
                    busy_next     = 1'b1;
                    level_next    = 1'b0;
                    res           = '0;
                    res.kind      = KIND_READ;
                    res.address   = {req.pte_word[XLEN-3:VPN_W],
                                     saved_vaddr_reg[OFFSET_W+VPN_W-1:OFFSET_W], 2'b00};
                    res.read_kind = saved_type_reg;
                end
            end
            else if (priv_mode_reg == PRIV_USER && !pte_u)
            begin
                // supervisor page touched from user mode: fault
            end
            else if (!perm || (check_ad_reg && ad_fault))
            begin
                // missing permission or accessed/dirty clear: fault
            end
            else if (level_reg)
            begin
                // superpage leaf must have PPN[0] clear
                if (req.pte_word[VPN_W+VPN_W-1:VPN_W] == '0)
                begin
                    res         = '0;
                    res.kind    = KIND_DONE;
                    res.address = {req.pte_word[XLEN-3:VPN_W+VPN_W],
                                   saved_vaddr_reg[OFFSET_W+VPN_W-1:OFFSET_W],
                                   {OFFSET_W{1'b0}}};
                end
            end
            else
            begin
                res         = '0;
                res.kind    = KIND_DONE;
                res.address = {req.pte_word[XLEN-3:VPN_W], {OFFSET_W{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg  <= '0;
            priv_mode_reg <= 1'b0;
            check_ad_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ROOT_PPN:  root_ppn_reg  <= cfg.data[PPN_W-1:0];
                CFG_PRIV_MODE: priv_mode_reg <= cfg.data[0];
                CFG_CHECK_AD:  check_ad_reg  <= cfg.data[0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            level_reg       <= 1'b1;
            saved_vaddr_reg <= '0;
            saved_type_reg  <= ACC_FETCH;
        end
        else if (accept)
        begin
            busy_reg        <= busy_next;
            level_reg       <= level_next;
            saved_vaddr_reg <= saved_vaddr_next;
            saved_type_reg  <= saved_type_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_reg.kind;
    assign rsp.address     = out_reg.address;
    assign rsp.read_kind   = out_reg.read_kind;
    assign rsp.fault_cause = out_reg.fault_cause;
    assign rsp.fault_vaddr = out_reg.fault_vaddr;

endmodule

`default_nettype wire

// ===== test/sv32ptw_walk_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Sv32 page table walker: follows register writes, predicts each step, compares.
module sv32ptw_walk_checker
    import sv32ptw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sv32ptw_in_if  req,
    sv32ptw_out_if rsp,
    sv32ptw_cfg_if cfg,
    output int     mismatch_count,
    output int     outstanding
);

    logic [PPN_W-1:0] root_ppn;
    logic             priv_mode;
    logic             check_ad;

    logic             walking;
    logic             at_level1;
    logic [XLEN-1:0]  walk_vaddr;
    logic [1:0]       walk_type;

    result_t          pending_results[$];

    // Advance the walk by one request or PTE word; returns 1 when a result is due.
    function automatic bit predict_walk_step(
        input  logic            func,
        input  logic [XLEN-1:0] va,
        input  logic [1:0]      acc,
        input  logic [XLEN-1:0] pte,
        output result_t         res
    );
        logic [XLEN-1:0] table_base;
        logic [XLEN-1:0] page_base;
        logic            perm_ok;
        logic            ad_missing;
        logic            faulted;
        res     = '0;
        faulted = 1'b0;
        if (func == FUNC_REQUEST)
        begin
            walk_vaddr = va;
            // the unused fourth access code walks as a store
            walk_type  = (acc > ACC_STORE) ? ACC_STORE : acc;
            walking    = 1'b1;
            at_level1  = 1'b1;
            table_base = {root_ppn[19:0], 12'b0};
            res.kind      = KIND_READ;
            res.address   = table_base + {20'b0, va[31:22], 2'b00};
            res.read_kind = walk_type;
            return 1'b1;
        end
        if (!walking)
            return 1'b0;

        page_base = {pte[29:10], 12'b0};
        if (!pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W]))
            faulted = 1'b1;
        else if (!pte[PTE_R] && !pte[PTE_X])
        begin
            if (!at_level1)
                faulted = 1'b1;
            else
            begin
                at_level1     = 1'b0;
                res.kind      = KIND_READ;
                res.address   = page_base + {20'b0, walk_vaddr[21:12], 2'b00};
                res.read_kind = walk_type;
                return 1'b1;
            end
        end
        else
        begin
            case (walk_type)
                ACC_FETCH:
                begin
                    perm_ok    = pte[PTE_X];
                    ad_missing = !pte[PTE_A];
                end
                ACC_LOAD:
                begin
                    perm_ok    = pte[PTE_R];
                    ad_missing = !pte[PTE_A];
                end
                default:
                begin
                    perm_ok    = pte[PTE_W];
                    ad_missing = !pte[PTE_A] || !pte[PTE_D];
                end
            endcase
            if (priv_mode == PRIV_USER && !pte[PTE_U])
                faulted = 1'b1;
            else if (!perm_ok || (check_ad && ad_missing))
                faulted = 1'b1;
            else if (at_level1 && pte[19:10] != 10'b0)
                faulted = 1'b1;
            else
            begin
                // superpage: take VPN[0] from the virtual address
                if (at_level1)
                    page_base[21:12] = walk_vaddr[21:12];
                res.kind    = KIND_DONE;
                res.address = page_base;
            end
        end

        if (faulted)
        begin
            res.kind        = KIND_FAULT;
            res.fault_cause = walk_type;
            res.fault_vaddr = walk_vaddr;
        end
        walking   = 1'b0;
        at_level1 = 1'b1;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t exp_res;
        result_t got_res;
        result_t next_res;
        if (!rst_n)
        begin
            root_ppn       = '0;
            priv_mode      = 1'b0;
            check_ad       = 1'b0;
            walking        = 1'b0;
            at_level1      = 1'b1;
            walk_vaddr     = '0;
            walk_type      = ACC_FETCH;
            pending_results.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ROOT_PPN:  root_ppn  = cfg.data[PPN_W-1:0];
                    CFG_PRIV_MODE: priv_mode = cfg.data[0];
                    CFG_CHECK_AD:  check_ad  = cfg.data[0];
                    default:       ;
                endcase
            end

            // drain before predicting so a same-edge transaction on both sides stays ordered
            if (rsp.valid && rsp.ready)
            begin
                got_res.kind        = rsp.kind;
                got_res.address     = rsp.address;
                got_res.read_kind   = rsp.read_kind;
                got_res.fault_cause = rsp.fault_cause;
                got_res.fault_vaddr = rsp.fault_vaddr;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual kind=%0d address=%h",
                             $time, got_res.kind, got_res.address,
                             " read_kind=%0d fault_cause=%0d fault_vaddr=%h",
                             got_res.read_kind, got_res.fault_cause, got_res.fault_vaddr);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (got_res.kind !== exp_res.kind || got_res.address !== exp_res.address ||
                        got_res.read_kind !== exp_res.read_kind ||
                        got_res.fault_cause !== exp_res.fault_cause ||
                        got_res.fault_vaddr !== exp_res.fault_vaddr)
                    begin
                        $display("%0t: result mismatch: expected kind=%0d address=%h", $time,
                                 exp_res.kind, exp_res.address,
                                 " read_kind=%0d fault_cause=%0d fault_vaddr=%h",
                                 exp_res.read_kind, exp_res.fault_cause, exp_res.fault_vaddr,
                                 ", actual kind=%0d address=%h", got_res.kind, got_res.address,
                                 " read_kind=%0d fault_cause=%0d fault_vaddr=%h",
                                 got_res.read_kind, got_res.fault_cause, got_res.fault_vaddr);
                        mismatch_count++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                if (predict_walk_step(req.func, req.vaddr, req.access_type, req.pte_word,
                                      next_res))
                    pending_results.push_back(next_res);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== test/tb_sv32_page_table_walker.sv =====
`timescale 1ns / 1ps
// Testbench top for the Sv32 page table walker: clock, reset, stimulus and verdict.
module tb_sv32_page_table_walker;
    import sv32ptw_pkg::*;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;
    int   mismatch_count;
    int   outstanding;

    sv32ptw_in_if  req_if ();
    sv32ptw_out_if rsp_if ();
    sv32ptw_cfg_if cfg_if ();

    sv32_page_table_walker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    sv32ptw_walk_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .rsp            (rsp_if),
        .cfg            (cfg_if),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("[sv32_page_table_walker] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic func, input logic [XLEN-1:0] va,
                             input logic [1:0] acc, input logic [XLEN-1:0] pte);
        // re-roll the idle chance at each falling edge so the idle share matches the percentage
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.func        = func;
        req_if.vaddr       = va;
        req_if.access_type = acc;
        req_if.pte_word    = pte;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Hold the request side idle until every result is out, then let the pipeline settle.
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [XLEN-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data  = data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
    endtask

    // Upper data bits are random; the block must mask them off.
    task automatic set_config(input logic [PPN_W-1:0] root, input logic priv, input logic chk);
        logic [XLEN-1:0] data;
        wait_drained();
        data = $urandom;
        data[PPN_W-1:0] = root;
        write_reg(CFG_ROOT_PPN, data);
        data = $urandom;
        data[0] = priv;
        write_reg(CFG_PRIV_MODE, data);
        data = $urandom;
        data[0] = chk;
        write_reg(CFG_CHECK_AD, data);
        cfg_if.valid = 1'b0;
    endtask

    // Leaf PTE that mostly grants the access; superpages are mostly aligned.
    function automatic logic [XLEN-1:0] make_leaf(input logic [1:0] acc, input bit superpage);
        logic [XLEN-1:0] pte;
        pte = $urandom;
        pte[PTE_V] = ($urandom_range(99) < 97);
        if ($urandom_range(99) < 75)
        begin
            case (acc)
                ACC_FETCH: pte[PTE_X] = 1'b1;
                ACC_LOAD:  pte[PTE_R] = 1'b1;
                default:
                begin
                    pte[PTE_R] = 1'b1;
                    pte[PTE_W] = 1'b1;
                end
            endcase
        end
        if (!pte[PTE_R] && !pte[PTE_X])
            pte[PTE_R] = 1'b1;
        if (pte[PTE_W] && !pte[PTE_R] && $urandom_range(99) < 80)
            pte[PTE_R] = 1'b1;
        pte[PTE_U] = ($urandom_range(99) < 75);
        pte[PTE_A] = ($urandom_range(99) < 85);
        pte[PTE_D] = ($urandom_range(99) < 80);
        if (superpage && $urandom_range(99) < 75)
            pte[19:10] = '0;
        return pte;
    endfunction

    function automatic logic [XLEN-1:0] make_pointer();
        logic [XLEN-1:0] pte;
        pte = $urandom;
        pte[PTE_V] = 1'b1;
        pte[PTE_R] = 1'b0;
        pte[PTE_W] = 1'b0;
        pte[PTE_X] = 1'b0;
        return pte;
    endfunction

    initial
    begin : stimulus
        int              phase;
        int              block;
        int              target;
        int              roll;
        logic [1:0]      acc;
        logic [PPN_W-1:0] root;

        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_REQUEST;
        req_if.vaddr       = '0;
        req_if.access_type = ACC_FETCH;
        req_if.pte_word    = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_ROOT_PPN;
        cfg_if.data        = '0;
        items_sent         = 0;
        send_idle_pct      = 15;
        recv_idle_pct      = 85;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: supervisor, no A/D check, root at the top of the PPN range
        set_config(22'h3fffff, 1'b0, 1'b0);
        send_item(FUNC_REQUEST, 32'h0000_0000, ACC_FETCH, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0000);      // invalid PTE
        send_item(FUNC_PTE, 32'hffff_ffff, 2'd3, 32'hffff_ffff);   // PTE while idle
        send_item(FUNC_REQUEST, 32'hffff_ffff, ACC_LOAD, 32'hffff_ffff);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'hffff_fc01);      // pointer, PPN all ones
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'hffff_ffff);      // level-0 leaf
        send_item(FUNC_REQUEST, 32'h0040_1000, ACC_STORE, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0005);      // write without read
        send_item(FUNC_REQUEST, 32'h1234_5678, 2'd3, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_04cf);      // misaligned superpage
        send_item(FUNC_REQUEST, 32'h8000_0000, ACC_FETCH, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0401);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0801);      // pointer at level 0
        send_item(FUNC_REQUEST, 32'hdead_beef, ACC_LOAD, 32'h0);
        send_item(FUNC_REQUEST, 32'h0abc_d123, ACC_STORE, 32'h0);  // abandons the load walk
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h2000_00c7);      // aligned superpage
        send_item(FUNC_REQUEST, 32'h0000_3000, ACC_FETCH, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0043);      // no execute permission

        // directed: user mode with A/D checking, root at zero
        set_config(22'h0, PRIV_USER, 1'b1);
        send_item(FUNC_REQUEST, 32'h0040_0000, ACC_LOAD, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_00c3);      // U clear
        send_item(FUNC_REQUEST, 32'h0040_0000, ACC_LOAD, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0013);      // A clear
        send_item(FUNC_REQUEST, 32'h0040_0000, ACC_STORE, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_0057);      // D clear on store
        send_item(FUNC_REQUEST, 32'h0040_0000, ACC_STORE, 32'h0);
        send_item(FUNC_PTE, 32'h0, ACC_FETCH, 32'h0000_00d7);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (block = 0; block < 3; block++)
            begin
                if (phase == 0 && block == 0)
                    set_config(22'h3fffff, PRIV_USER, 1'b1);
                else if (phase == 0 && block == 1)
                    set_config(22'h0, 1'b0, 1'b0);
                else
                begin
                    roll = $urandom_range(2);
                    root = (roll == 0) ? 22'h0 : (roll == 1) ? 22'h3fffff : 22'($urandom);
                    set_config(root, 1'($urandom), 1'($urandom));
                end
                target = items_sent + 100;
                while (items_sent < target)
                begin
                    roll = $urandom_range(99);
                    if (roll < 85)
                    begin
                        acc = 2'($urandom_range(3));
                        send_item(FUNC_REQUEST, $urandom, acc, $urandom);
                        roll = $urandom_range(99);
                        if (roll < 40)
                        begin
                            send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)),
                                      make_pointer());
                            roll = $urandom_range(99);
                            if (roll < 75)
                                send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)),
                                          make_leaf(acc, 1'b0));
                            else if (roll < 85)
                                send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)),
                                          make_pointer());
                            else if (roll < 93)
                                send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)),
                                          $urandom);
                            // otherwise leave the walk for the next request to abandon
                        end
                        else if (roll < 85)
                            send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)),
                                      make_leaf(acc, 1'b1));
                        else
                            send_item(FUNC_PTE, $urandom, 2'($urandom_range(3)), $urandom);
                    end
                    else
                        send_item(1'($urandom), $urandom, 2'($urandom_range(3)), $urandom);
                end
            end
        end

        wait_drained();
        repeat (6) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[sv32_page_table_walker] OK");
        else
            $display("[sv32_page_table_walker] ERROR");
        $finish;
    end

endmodule
